// File: design/bga_pkg.sv
// shared types and constants of the best goal arbiter
`timescale 1ns / 1ps
package bga_pkg;

    localparam int POS_W   = 24;
    localparam int SCORE_W = 32;
    localparam int TIME_W  = 32;
    localparam int DIST_W  = 24;
    localparam int MARGIN_W = 31;
    localparam int SRC_W   = 3;
    localparam int CFG_AW  = 2;
    localparam int CFG_DW  = 32;

    localparam logic [TIME_W-1:0]   STALE_RST   = 32'd5000;
    localparam logic [TIME_W-1:0]   TIMEOUT_RST = 32'd70000;
    localparam logic [DIST_W-1:0]   DIST_RST    = 24'd500;
    localparam logic [MARGIN_W-1:0] MARGIN_RST  = 31'd1000;

    typedef enum logic [1:0] {
        OP_CAND   = 2'd0,
        OP_TICK   = 2'd1,
        OP_REJECT = 2'd2,
        OP_END    = 2'd3
    } t_op;

    typedef enum logic [CFG_AW-1:0] {
        CFG_STALE   = 2'd0,
        CFG_TIMEOUT = 2'd1,
        CFG_DIST    = 2'd2,
        CFG_MARGIN  = 2'd3
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_MULT,
        S_DECIDE
    } t_state;

    typedef struct packed {
        logic [POS_W-1:0]   x;
        logic [POS_W-1:0]   y;
        logic [SCORE_W-1:0] score;
        logic [TIME_W-1:0]  stamp;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

    typedef struct packed {
        logic cand_wr;
        logic tick_start;
        logic clr_active;
        logic scan_rd;
        logic mult_en;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic resend;
        logic out_free;
    } t_dp_sts;

endpackage

// File: design/bga_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module bga_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: design/bga_ctrl.sv
// controller state machine: transaction decode, slot scan sequencing, decision
`timescale 1ns / 1ps
module bga_ctrl
    import bga_pkg::*;
#(
    parameter int NUM_SOURCES = 8,
    localparam int IDX_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [1:0]       i_op,
    input  logic             i_server_ready,
    output logic             o_ready,
    output t_dp_cmd          o_cmd,
    output logic [IDX_W-1:0] o_rd_addr,
    input  t_dp_sts          i_sts
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SOURCES - 1);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        o_ready   = 1'b0;
        o_cmd     = '0;
        o_rd_addr = r_cnt;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    case (t_op'(i_op))
                        OP_CAND: begin
                            o_cmd.cand_wr = 1'b1;
                        end
                        OP_TICK: begin
                            if (i_server_ready) begin
                                o_cmd.tick_start = 1'b1;
                                n_cnt   = '0;
                                n_state = S_SCAN;
                            end
                        end
                        OP_REJECT, OP_END: begin
                            o_cmd.clr_active = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (r_cnt == LAST_IDX) begin
                    n_state = S_DRAIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DRAIN: begin
                n_state = S_MULT;
            end
            S_MULT: begin
                o_cmd.mult_en = 1'b1;
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (!i_sts.resend) begin
                    n_state = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: design/bga_dp.sv
// datapath: config registers, slot store, best-slot search, resend tests, output register
`timescale 1ns / 1ps
module bga_dp
    import bga_pkg::*;
#(
    parameter int NUM_SOURCES = 8,
    localparam int IDX_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_AW-1:0]     i_cfg_addr,
    input  logic [CFG_DW-1:0]     i_cfg_wr_data,
    input  logic [SRC_W-1:0]      i_source_index,
    input  logic signed [POS_W-1:0]   i_pos_x,
    input  logic signed [POS_W-1:0]   i_pos_y,
    input  logic signed [SCORE_W-1:0] i_cand_score,
    input  logic [TIME_W-1:0]     i_timestamp_ms,
    input  t_dp_cmd               i_cmd,
    input  logic [IDX_W-1:0]      i_rd_addr,
    output t_dp_sts               o_sts,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic signed [POS_W-1:0]   o_goal_x,
    output logic signed [POS_W-1:0]   o_goal_y,
    output logic signed [SCORE_W-1:0] o_goal_score,
    output logic [SRC_W-1:0]      o_goal_source
);

    localparam int CMP_W = SRC_W + IDX_W + 1;

    // config registers
    logic [TIME_W-1:0]   r_stale, r_timeout;
    logic [DIST_W-1:0]   r_dist;
    logic [MARGIN_W-1:0] r_margin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stale   <= STALE_RST;
            r_timeout <= TIMEOUT_RST;
            r_dist    <= DIST_RST;
            r_margin  <= MARGIN_RST;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_reg'(i_cfg_addr))
                CFG_STALE:   r_stale   <= i_cfg_wr_data;
                CFG_TIMEOUT: r_timeout <= i_cfg_wr_data;
                CFG_DIST:    r_dist    <= i_cfg_wr_data[DIST_W-1:0];
                CFG_MARGIN:  r_margin  <= i_cfg_wr_data[MARGIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // slot store
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_slot            wr_slot, rd_slot;

    assign wr_en   = i_cmd.cand_wr && (CMP_W'(i_source_index) < CMP_W'(NUM_SOURCES));
    assign wr_addr = IDX_W'(i_source_index);
    assign wr_slot = '{x: i_pos_x, y: i_pos_y, score: i_cand_score, stamp: i_timestamp_ms};

    bga_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (NUM_SOURCES)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_slot),
        .i_rd_en   (i_cmd.scan_rd),
        .i_rd_addr (i_rd_addr),
        .o_rd_data (rd_slot)
    );

    // scan and best-slot tracking
    logic [NUM_SOURCES-1:0] r_slot_vld;
    logic                   r_eval_vld;
    logic [IDX_W-1:0]       r_eval_idx;
    logic [TIME_W-1:0]      r_now;
    logic                   r_found;
    t_slot                  r_best;
    logic [IDX_W-1:0]       r_best_idx;
    logic [TIME_W-1:0]      age;
    logic                   stale;
    logic                   higher;

    assign age    = r_now - rd_slot.stamp;
    assign stale  = age > r_stale;
    assign higher = $signed(rd_slot.score) > $signed(r_best.score);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_vld <= '0;
            r_eval_vld <= 1'b0;
            r_found    <= 1'b0;
        end else begin
            r_eval_vld <= i_cmd.scan_rd;
            if (wr_en) begin
                r_slot_vld[wr_addr] <= 1'b1;
            end
            if (i_cmd.tick_start) begin
                r_found <= 1'b0;
            end else if (r_eval_vld && r_slot_vld[r_eval_idx]) begin
                if (stale) begin
                    r_slot_vld[r_eval_idx] <= 1'b0;
                end else if (!r_found || higher) begin
                    r_found <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_eval_idx <= i_rd_addr;
        if (i_cmd.tick_start) begin
            r_now <= i_timestamp_ms;
        end
        if (r_eval_vld && r_slot_vld[r_eval_idx] && !stale && (!r_found || higher)) begin
            r_best     <= rd_slot;
            r_best_idx <= r_eval_idx;
        end
    end

    // active goal
    logic                r_active;
    logic [POS_W-1:0]    r_act_x, r_act_y;
    logic [SCORE_W-1:0]  r_act_score;
    logic [TIME_W-1:0]   r_sent;

    // resend tests, products registered
    logic signed [POS_W:0]     dx, dy;
    logic signed [2*POS_W+1:0] dx_sq, dy_sq;
    logic [2*POS_W+1:0]        r_dx2, r_dy2;
    logic [2*DIST_W-1:0]       r_r2;
    logic signed [SCORE_W+1:0] lhs, rhs;
    logic                      r_better, r_timed;
    logic [2*POS_W+2:0]        d2;
    logic                      moved;

    assign dx    = $signed({r_best.x[POS_W-1], r_best.x}) - $signed({r_act_x[POS_W-1], r_act_x});
    assign dy    = $signed({r_best.y[POS_W-1], r_best.y}) - $signed({r_act_y[POS_W-1], r_act_y});
    assign dx_sq = dx * dx;
    assign dy_sq = dy * dy;
    assign lhs   = $signed({{2{r_best.score[SCORE_W-1]}}, r_best.score});
    assign rhs   = $signed({{2{r_act_score[SCORE_W-1]}}, r_act_score})
                 + $signed({3'b000, r_margin});

    always_ff @(posedge i_clk) begin
        if (i_cmd.mult_en) begin
            r_dx2    <= $unsigned(dx_sq);
            r_dy2    <= $unsigned(dy_sq);
            r_r2     <= r_dist * r_dist;
            r_better <= lhs > rhs;
            r_timed  <= (r_now - r_sent) > r_timeout;
        end
    end

    assign d2    = (2*POS_W+3)'(r_dx2) + (2*POS_W+3)'(r_dy2);
    assign moved = d2 > (2*POS_W+3)'(r_r2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_act_x     <= '0;
            r_act_y     <= '0;
            r_act_score <= '0;
            r_sent      <= '0;
        end else if (i_cmd.commit) begin
            r_active    <= 1'b1;
            r_act_x     <= r_best.x;
            r_act_y     <= r_best.y;
            r_act_score <= r_best.score;
            r_sent      <= r_now;
        end else if (i_cmd.clr_active) begin
            r_active <= 1'b0;
        end
    end

    // output register
    logic                r_out_vld;
    logic [POS_W-1:0]    r_out_x, r_out_y;
    logic [SCORE_W-1:0]  r_out_score;
    logic [SRC_W-1:0]    r_out_src;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_x     <= r_best.x;
            r_out_y     <= r_best.y;
            r_out_score <= r_best.score;
            r_out_src   <= SRC_W'(r_best_idx);
        end
    end

    assign o_sts.resend   = r_found && (!r_active || moved || r_better || r_timed);
    assign o_sts.out_free = !r_out_vld || i_ready;

    assign o_valid       = r_out_vld;
    assign o_goal_x      = r_out_x;
    assign o_goal_y      = r_out_y;
    assign o_goal_score  = r_out_score;
    assign o_goal_source = r_out_src;

endmodule

// File: design/best_goal_arbiter_with_resend_hysteresis_core.sv
// top level of the best goal arbiter with resend hysteresis
//
//  channel   handshake           payload
//  input     i_valid / o_ready   i_op, i_source_index, i_pos_x, i_pos_y, i_cand_score,
//                                i_timestamp_ms, i_server_ready
//  output    o_valid / i_ready   o_goal_x, o_goal_y, o_goal_score, o_goal_source
//  config    i_cfg_wr_en         i_cfg_addr, i_cfg_wr_data
//
// candidate, reject and end transactions complete in the idle state; a tick with the server
// not ready is accepted there too and starts nothing.
// a ready tick runs the states scan, drain, mult and decide: one slot ram read per cycle
// in scan, the last compare in drain, the distance products in mult, then the decision.
// a decision to send holds while an earlier result waits in the output register.
// reset is synchronous and clears valid bits, active goal and config to defaults.
`timescale 1ns / 1ps
module best_goal_arbiter_with_resend_hysteresis_core
    import bga_pkg::*;
#(
    parameter int NUM_SOURCES = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [CFG_AW-1:0]         i_cfg_addr,
    input  logic [CFG_DW-1:0]         i_cfg_wr_data,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [1:0]                i_op,
    input  logic [SRC_W-1:0]          i_source_index,
    input  logic signed [POS_W-1:0]   i_pos_x,
    input  logic signed [POS_W-1:0]   i_pos_y,
    input  logic signed [SCORE_W-1:0] i_cand_score,
    input  logic [TIME_W-1:0]         i_timestamp_ms,
    input  logic                      i_server_ready,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [POS_W-1:0]   o_goal_x,
    output logic signed [POS_W-1:0]   o_goal_y,
    output logic signed [SCORE_W-1:0] o_goal_score,
    output logic [SRC_W-1:0]          o_goal_source
);

    localparam int IDX_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;

    t_dp_cmd          cmd;
    t_dp_sts          sts;
    logic [IDX_W-1:0] rd_addr;

    bga_ctrl #(
        .NUM_SOURCES (NUM_SOURCES)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_op           (i_op),
        .i_server_ready (i_server_ready),
        .o_ready        (o_ready),
        .o_cmd          (cmd),
        .o_rd_addr      (rd_addr),
        .i_sts          (sts)
    );

    bga_dp #(
        .NUM_SOURCES (NUM_SOURCES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_source_index (i_source_index),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_cand_score   (i_cand_score),
        .i_timestamp_ms (i_timestamp_ms),
        .i_cmd          (cmd),
        .i_rd_addr      (rd_addr),
        .o_sts          (sts),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_goal_x       (o_goal_x),
        .o_goal_y       (o_goal_y),
        .o_goal_score   (o_goal_score),
        .o_goal_source  (o_goal_source)
    );

endmodule
